/* hw/rtl/rrtl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrtl_pkg
// shared types and codes for the rectangle region table lookup block
// ---------------------------------------------------------------------------
package rrtl_pkg;

   localparam int CoordWidth  = 14;
   localparam int ExtentWidth = 8;
   localparam int ParentWidth = 5;

   localparam logic [ParentWidth-1:0] PARENT_NONE = 5'd31;

   typedef enum logic [2:0] {
      MODE_LOOKUP   = 3'd0,
      MODE_REGISTER = 3'd1,
      MODE_RELEASE  = 3'd2,
      MODE_QUERY    = 3'd3,
      MODE_CLEAR    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK              = 3'd0,
      ST_BAD_SLOT        = 3'd1,
      ST_SLOT_BUSY       = 3'd2,
      ST_NOT_LIVE        = 3'd3,
      ST_PARENT_NOT_LIVE = 3'd4,
      ST_ZERO_SIZE       = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_QUERY = 3'b010,
      S_SCAN  = 3'b100
   } state_type;

   typedef struct packed {
      logic [CoordWidth-1:0]  base_x;
      logic [CoordWidth-1:0]  base_z;
      logic [ExtentWidth-1:0] size_x;
      logic [ExtentWidth-1:0] size_z;
      logic [ParentWidth-1:0] parent;
   } entry_type;

   typedef struct packed {
      logic                  hit;
      logic [CoordWidth-1:0] local_x;
      logic [CoordWidth-1:0] local_z;
   } match_type;

endpackage
`default_nettype wire

/* hw/rtl/rectangle_region_table_lookup_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rectangle_region_table_lookup_top
// table of view slots with register, release, query, clear and tile lookup
//
// request words enter on req_* (valid/ready), one result word per request
// leaves on rsp_* (valid/ready). one request is handled at a time.
// register, release, clear and unused modes answer at the accept edge, so
// their result word is valid the next cycle. query reads the slot ram at
// accept and loads its word from the registered read data in S_QUERY.
// lookup streams slots 1 upward through the ram read port, one slot per
// cycle, and checks each in the cycle after its read; a hit ends the scan
// at the first matching slot, a miss ends it once the last slot is checked.
// live bits sit in flip-flops, the rest of each slot in the ram; a slot that
// is not live reads as empty, so reset and clear need no ram sweep. a new
// request is taken only when the result register is empty or being drained
// in the same cycle; a stalled receiver holds the result and blocks further
// requests.
// ---------------------------------------------------------------------------
module rectangle_region_table_lookup_top
   import rrtl_pkg::*;
#(
   parameter int SLOT_COUNT = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [2:0]            req_mode,
   input  wire logic [3:0]            req_view_slot,
   input  wire logic [CoordWidth-1:0] req_corner_x,
   input  wire logic [CoordWidth-1:0] req_corner_z,
   input  wire logic [7:0]            req_extent_x,
   input  wire logic [7:0]            req_extent_z,
   input  wire logic [3:0]            req_parent_slot,
   input  wire logic [CoordWidth-1:0] req_tile_x,
   input  wire logic [CoordWidth-1:0] req_tile_z,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [2:0]            rsp_status,
   output      logic [3:0]            rsp_home_slot,
   output      logic [CoordWidth-1:0] rsp_local_x,
   output      logic [CoordWidth-1:0] rsp_local_z,
   output      logic                  rsp_slot_live,
   output      logic [4:0]            rsp_slot_parent
);

   localparam int SW = $clog2(SLOT_COUNT);
   localparam logic [6:0]    SlotLimit = 7'(SLOT_COUNT);
   localparam logic [SW-1:0] LastSlot  = SW'(SLOT_COUNT - 1);
   localparam logic [SW-1:0] FirstSlot = SW'(1);

   state_type state_ff, state_in;
   logic [SLOT_COUNT-1:0] live_ff, live_in;
   logic [3:0]            slot_ff, slot_in;
   logic [CoordWidth-1:0] tx_ff, tx_in, tz_ff, tz_in;
   logic [SW-1:0]         scan_ff, scan_in, chk_slot_ff, chk_slot_in;
   logic                  issue_done_ff, issue_done_in, chk_vld_ff, chk_vld_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [3:0]            rsp_home_ff, rsp_home_in;
   logic [CoordWidth-1:0] rsp_lx_ff, rsp_lx_in, rsp_lz_ff, rsp_lz_in;
   logic                  rsp_live_ff, rsp_live_in;
   logic [4:0]            rsp_parent_ff, rsp_parent_in;
   logic                  rsp_load;

   logic                  req_fire, out_free;
   logic                  view_ok, parent_ok, query_ok;
   logic [SW-1:0]         view_idx, parent_idx, query_idx;

   logic                  wr_en, rd_en;
   logic [SW-1:0]         wr_addr, rd_addr;
   entry_type             wr_entry, rd_entry;
   match_type             match;
   logic                  scan_hit;

   rrtl_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   rrtl_match u_match (
      .entry  (rd_entry),
      .tile_x (tx_ff),
      .tile_z (tz_ff),
      .result (match)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   assign view_ok    = {3'b000, req_view_slot} < SlotLimit;
   assign parent_ok  = {3'b000, req_parent_slot} < SlotLimit;
   assign query_ok   = {3'b000, slot_ff} < SlotLimit;
   assign view_idx   = SW'(req_view_slot);
   assign parent_idx = SW'(req_parent_slot);
   assign query_idx  = SW'(slot_ff);

   assign scan_hit = chk_vld_ff && live_ff[chk_slot_ff] && match.hit;

   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      slot_in       = slot_ff;
      tx_in         = tx_ff;
      tz_in         = tz_ff;
      scan_in       = scan_ff;
      chk_slot_in   = chk_slot_ff;
      issue_done_in = issue_done_ff;
      chk_vld_in    = 1'b0;

      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_home_in   = '0;
      rsp_lx_in     = '0;
      rsp_lz_in     = '0;
      rsp_live_in   = 1'b0;
      rsp_parent_in = PARENT_NONE;

      wr_en    = 1'b0;
      wr_addr  = view_idx;
      wr_entry = '{base_x: req_corner_x, base_z: req_corner_z,
                   size_x: req_extent_x, size_z: req_extent_z,
                   parent: {1'b0, req_parent_slot}};
      rd_en    = 1'b0;
      rd_addr  = view_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               slot_in = req_view_slot;
               case (req_mode)
                  MODE_LOOKUP: begin
                     tx_in         = req_tile_x;
                     tz_in         = req_tile_z;
                     scan_in       = FirstSlot;
                     issue_done_in = 1'b0;
                     state_in      = S_SCAN;
                  end
                  MODE_REGISTER: begin
                     rsp_load = 1'b1;
                     if (req_view_slot == '0) begin
                        if (live_ff[0]) begin
                           rsp_status_in = ST_SLOT_BUSY;
                        end else begin
                           live_in[0] = 1'b1;
                           wr_en      = 1'b1;
                           wr_entry   = '{base_x: '0, base_z: '0, size_x: '0,
                                          size_z: '0, parent: PARENT_NONE};
                        end
                     end else if (!view_ok) begin
                        rsp_status_in = ST_BAD_SLOT;
                     end else if ((req_extent_x == '0) || (req_extent_z == '0)) begin
                        rsp_status_in = ST_ZERO_SIZE;
                     end else if (!parent_ok || !live_ff[parent_idx]) begin
                        rsp_status_in = ST_PARENT_NOT_LIVE;
                     end else if (live_ff[view_idx]) begin
                        rsp_status_in = ST_SLOT_BUSY;
                     end else begin
                        live_in[view_idx] = 1'b1;
                        wr_en             = 1'b1;
                     end
                  end
                  MODE_RELEASE: begin
                     rsp_load = 1'b1;
                     if ((req_view_slot == '0) || !view_ok) begin
                        rsp_status_in = ST_BAD_SLOT;
                     end else if (!live_ff[view_idx]) begin
                        rsp_status_in = ST_NOT_LIVE;
                     end else begin
                        live_in[view_idx] = 1'b0;
                     end
                  end
                  MODE_QUERY: begin
                     rd_en    = 1'b1;
                     state_in = S_QUERY;
                  end
                  MODE_CLEAR: begin
                     rsp_load = 1'b1;
                     live_in  = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_QUERY: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
            if (!query_ok) begin
               rsp_status_in = ST_BAD_SLOT;
            end else if (live_ff[query_idx]) begin
               rsp_live_in   = 1'b1;
               rsp_parent_in = rd_entry.parent;
            end
         end
         S_SCAN: begin
            rd_addr = scan_ff;
            if (!issue_done_ff) begin
               rd_en       = 1'b1;
               chk_vld_in  = 1'b1;
               chk_slot_in = scan_ff;
               if (scan_ff == LastSlot) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_in = scan_ff + FirstSlot;
               end
            end
            if (scan_hit) begin
               rsp_load    = 1'b1;
               rsp_home_in = 4'(chk_slot_ff);
               rsp_lx_in   = match.local_x;
               rsp_lz_in   = match.local_z;
               state_in    = S_IDLE;
            end else if (chk_vld_ff && (chk_slot_ff == LastSlot)) begin
               rsp_load  = 1'b1;
               rsp_lx_in = tx_ff;
               rsp_lz_in = tz_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      tx_ff         <= tx_in;
      tz_ff         <= tz_in;
      scan_ff       <= scan_in;
      chk_slot_ff   <= chk_slot_in;
      issue_done_ff <= issue_done_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_home_ff   <= rsp_home_in;
         rsp_lx_ff     <= rsp_lx_in;
         rsp_lz_ff     <= rsp_lz_in;
         rsp_live_ff   <= rsp_live_in;
         rsp_parent_ff <= rsp_parent_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_home_slot   = rsp_home_ff;
   assign rsp_local_x     = rsp_lx_ff;
   assign rsp_local_z     = rsp_lz_ff;
   assign rsp_slot_live   = rsp_live_ff;
   assign rsp_slot_parent = rsp_parent_ff;

   // root survives any release
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == MODE_RELEASE)) |=> (live_ff[0] == $past(live_ff[0])))
      else $error("release changed the root live bit");

   // clear leaves no live slot
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == MODE_CLEAR)) |=> (live_ff == '0))
      else $error("clear left a live slot");

   // a lookup home slot other than root is live while its word is held
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_home_ff != '0)) |-> live_ff[SW'(rsp_home_ff)])
      else $error("lookup word names a slot that is not live");

   // no result word is pending while a query or lookup is in flight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result word pending during a multi-cycle request");

endmodule
`default_nettype wire

/* hw/rtl/rrtl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrtl_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module rrtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/rrtl_match.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrtl_match
// half-open rectangle containment test and local offset for one entry
// ---------------------------------------------------------------------------
module rrtl_match
   import rrtl_pkg::*;
(
   input  wire entry_type             entry,
   input  wire logic [CoordWidth-1:0] tile_x,
   input  wire logic [CoordWidth-1:0] tile_z,
   output      match_type             result
);

   logic [CoordWidth:0] end_x;
   logic [CoordWidth:0] end_z;
   logic                at_origin;
   logic                in_x;
   logic                in_z;

   always_comb begin
      end_x     = {1'b0, entry.base_x} + {{(CoordWidth+1-ExtentWidth){1'b0}}, entry.size_x};
      end_z     = {1'b0, entry.base_z} + {{(CoordWidth+1-ExtentWidth){1'b0}}, entry.size_z};
      at_origin = (entry.base_x == '0) && (entry.base_z == '0);
      in_x      = (tile_x >= entry.base_x) && ({1'b0, tile_x} < end_x);
      in_z      = (tile_z >= entry.base_z) && ({1'b0, tile_z} < end_z);
      result.hit     = !at_origin && in_x && in_z;
      result.local_x = tile_x - entry.base_x;
      result.local_z = tile_z - entry.base_z;
   end

endmodule
`default_nettype wire
